FILE: hdl/wbpt_pkg.sv
package wbpt_pkg;

  // counter and result widths
  localparam int CNT_W  = 64;
  localparam int PCT_W  = 7;
  localparam int STAT_W = 2;

  // checkpoint ring, depth must be a power of two
  localparam int RING_SLOTS = 16;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int RING_SHIFT = $clog2(RING_SLOTS);
  localparam int FILL_W     = $clog2(RING_SLOTS + 1);

  // one ring entry holds a busy and a wall reading
  localparam int ENTRY_W = 2 * CNT_W;

  // quotient bits of the percent divide and the scaled numerator width
  localparam int QUO_W  = PCT_W;
  localparam int REM_W  = CNT_W + QUO_W;
  localparam int STEP_W = $clog2(QUO_W);

endpackage

FILE: hdl/wbpt_ifs.sv
// sample channel
interface wbpt_in_if;
  logic                       valid;
  logic                       ready;
  logic [wbpt_pkg::CNT_W-1:0] busy_count;
  logic [wbpt_pkg::CNT_W-1:0] wall_count;

  modport source (output valid, busy_count, wall_count, input ready);
  modport sink   (input valid, busy_count, wall_count, output ready);
endinterface

// result channel
interface wbpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [wbpt_pkg::PCT_W-1:0]  busy_percent;
  logic [wbpt_pkg::STAT_W-1:0] sample_status;

  modport source (output valid, busy_percent, sample_status, input ready);
  modport sink   (input valid, busy_percent, sample_status, output ready);
endinterface

FILE: hdl/wbpt_ram.sv
module wbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/windowed_busy_percent_tracker_top.sv
// baseline and rebase beats go from the order checks to output; others take the deltas,
// then distance and spacing before output; saturated ones also compare, divided ones also
// compare, scale and divide; one sample beat at a time, the next taken the cycle after the
// result is registered, the seven-step restoring divide on the shared subtractor setting
// the worst case; a stalled result holds the sequencer in its output state
// reset: rst_n synchronous active low clears control, window, baseline and ring fill
module windowed_busy_percent_tracker_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wbpt_pkg::CNT_W-1:0] cfg_wdata,
  wbpt_in_if.sink                    in_bus,
  wbpt_out_if.source                 out_bus
);

  localparam logic [wbpt_pkg::STAT_W-1:0] ST_BASELINE = 2'd0;
  localparam logic [wbpt_pkg::STAT_W-1:0] ST_RECOMP   = 2'd1;
  localparam logic [wbpt_pkg::STAT_W-1:0] ST_HELD     = 2'd2;
  localparam logic [wbpt_pkg::STAT_W-1:0] ST_REBASED  = 2'd3;

  localparam logic [wbpt_pkg::PCT_W-1:0] PCT_FULL = wbpt_pkg::PCT_W'(100);
  localparam int AW = wbpt_pkg::REM_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ORDER_B, S_ORDER_W, S_DELTA_B, S_DELTA_W, S_CMP,
    S_SCALE, S_DIV, S_DIST, S_SPACE, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [wbpt_pkg::CNT_W-1:0]  window_r;
  logic [wbpt_pkg::CNT_W-1:0]  busy_r, busy_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  wall_r, wall_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  prev_busy_r, prev_busy_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  prev_wall_r, prev_wall_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  commit_wall_r, commit_wall_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  db_r, db_nxt;
  logic [wbpt_pkg::CNT_W-1:0]  dw_r, dw_nxt;
  logic [wbpt_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [wbpt_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [wbpt_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        seen_first_r, seen_first_nxt;
  logic [wbpt_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [wbpt_pkg::SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [wbpt_pkg::PCT_W-1:0]  held_r, held_nxt;
  logic [wbpt_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [wbpt_pkg::PCT_W-1:0]  out_pct_r, out_pct_nxt;
  logic [wbpt_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  // ring port
  logic                          ram_we;
  logic [wbpt_pkg::SLOT_W-1:0]   ram_waddr;
  logic [wbpt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [wbpt_pkg::SLOT_W-1:0]   ram_raddr;
  logic [wbpt_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [wbpt_pkg::CNT_W-1:0]    ob, ow;

  // shared subtractor
  logic [wbpt_pkg::REM_W-1:0] alu_a, alu_b;
  logic [AW-1:0]              alu_diff;
  logic                       alu_lt;

  logic [wbpt_pkg::CNT_W-1:0] win, spacing_raw, spacing;
  logic [wbpt_pkg::REM_W-1:0] db_wide, dw_wide;
  logic                       in_fire, out_free;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready          = (state_r == S_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.busy_percent  = out_pct_r;
  assign out_bus.sample_status = out_stat_r;

  // oldest checkpoint: slot 0 until the ring is full, then the next to go
  assign ram_raddr = (fill_r < wbpt_pkg::FILL_W'(wbpt_pkg::RING_SLOTS)) ?
                     '0 : wslot_r;
  assign ob = ram_rdata[wbpt_pkg::ENTRY_W-1:wbpt_pkg::CNT_W];
  assign ow = ram_rdata[wbpt_pkg::CNT_W-1:0];

  wbpt_ram #(
    .WIDTH (wbpt_pkg::ENTRY_W),
    .DEPTH (wbpt_pkg::RING_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // checkpoint spacing, window of zero acts as one
  assign win         = (window_r == '0) ? wbpt_pkg::CNT_W'(1) : window_r;
  assign spacing_raw = win >> wbpt_pkg::RING_SHIFT;
  assign spacing     = (spacing_raw == '0) ? wbpt_pkg::CNT_W'(1) : spacing_raw;

  assign db_wide = wbpt_pkg::REM_W'(db_r);
  assign dw_wide = wbpt_pkg::REM_W'(dw_r);

  // operand select for the subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_ORDER_B: begin
        alu_a = wbpt_pkg::REM_W'(busy_r);
        alu_b = wbpt_pkg::REM_W'(prev_busy_r);
      end
      S_ORDER_W: begin
        alu_a = wbpt_pkg::REM_W'(wall_r);
        alu_b = wbpt_pkg::REM_W'(prev_wall_r);
      end
      S_DELTA_B: begin
        alu_a = wbpt_pkg::REM_W'(busy_r);
        alu_b = wbpt_pkg::REM_W'(ob);
      end
      S_DELTA_W: begin
        alu_a = wbpt_pkg::REM_W'(wall_r);
        alu_b = wbpt_pkg::REM_W'(ow);
      end
      S_CMP: begin
        alu_a = db_wide;
        alu_b = dw_wide;
      end
      S_DIV: begin
        alu_a = rem_r;
        alu_b = dw_wide << step_r;
      end
      S_DIST: begin
        alu_a = wbpt_pkg::REM_W'(wall_r);
        alu_b = wbpt_pkg::REM_W'(commit_wall_r);
      end
      S_SPACE: begin
        alu_a = db_wide;
        alu_b = wbpt_pkg::REM_W'(spacing);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt   = alu_diff[AW-1];

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    busy_nxt        = busy_r;
    wall_nxt        = wall_r;
    prev_busy_nxt   = prev_busy_r;
    prev_wall_nxt   = prev_wall_r;
    commit_wall_nxt = commit_wall_r;
    db_nxt          = db_r;
    dw_nxt          = dw_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    seen_first_nxt  = seen_first_r;
    fill_nxt        = fill_r;
    wslot_nxt       = wslot_r;
    held_nxt        = held_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_bus.ready;
    out_pct_nxt     = out_pct_r;
    out_stat_nxt    = out_stat_r;
    ram_we          = 1'b0;
    ram_waddr       = wslot_r;
    ram_wdata       = {busy_r, wall_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          busy_nxt  = in_bus.busy_count;
          wall_nxt  = in_bus.wall_count;
          state_nxt = S_ORDER_B;
        end
      end
      // first beat seeds slot 0, else check busy for going backwards
      S_ORDER_B: begin
        if (!seen_first_r) begin
          seen_first_nxt  = 1'b1;
          prev_busy_nxt   = busy_r;
          prev_wall_nxt   = wall_r;
          commit_wall_nxt = wall_r;
          ram_we          = 1'b1;
          ram_waddr       = '0;
          fill_nxt        = wbpt_pkg::FILL_W'(1);
          wslot_nxt       = (wbpt_pkg::RING_SLOTS > 1) ? wbpt_pkg::SLOT_W'(1) : '0;
          status_nxt      = ST_BASELINE;
          state_nxt       = S_OUT;
        end else if (alu_lt) begin
          prev_busy_nxt = busy_r;
          prev_wall_nxt = wall_r;
          status_nxt    = ST_REBASED;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_ORDER_W;
        end
      end
      S_ORDER_W: begin
        prev_busy_nxt = busy_r;
        prev_wall_nxt = wall_r;
        if (alu_lt) begin
          status_nxt = ST_REBASED;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_DELTA_B;
        end
      end
      S_DELTA_B: begin
        db_nxt    = alu_diff[wbpt_pkg::CNT_W-1:0];
        state_nxt = S_DELTA_W;
      end
      // no elapsed wall time against the checkpoint, or wall below it, holds the percent
      S_DELTA_W: begin
        dw_nxt = alu_diff[wbpt_pkg::CNT_W-1:0];
        if (alu_lt || alu_diff == '0) begin
          status_nxt = ST_HELD;
          state_nxt  = S_DIST;
        end else begin
          status_nxt = ST_RECOMP;
          state_nxt  = S_CMP;
        end
      end
      // busy delta at or above wall delta saturates
      S_CMP: begin
        if (!alu_lt) begin
          held_nxt  = PCT_FULL;
          state_nxt = S_DIST;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      // numerator times 100 as shifted adds
      S_SCALE: begin
        rem_nxt   = (db_wide << 6) + (db_wide << 5) + (db_wide << 2);
        quo_nxt   = '0;
        step_nxt  = wbpt_pkg::STEP_W'(wbpt_pkg::QUO_W - 1);
        state_nxt = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (!alu_lt) begin
          rem_nxt = alu_diff[wbpt_pkg::REM_W-1:0];
        end
        quo_nxt = {quo_r[wbpt_pkg::QUO_W-2:0], !alu_lt};
        if (step_r == '0) begin
          held_nxt  = {quo_r[wbpt_pkg::QUO_W-2:0], !alu_lt};
          state_nxt = S_DIST;
        end else begin
          step_nxt = step_r - wbpt_pkg::STEP_W'(1);
        end
      end
      S_DIST: begin
        db_nxt    = alu_diff[wbpt_pkg::CNT_W-1:0];
        state_nxt = S_SPACE;
      end
      // commit a checkpoint once far enough from the last one
      S_SPACE: begin
        if (!alu_lt) begin
          ram_we          = 1'b1;
          ram_waddr       = wslot_r;
          wslot_nxt       = (wslot_r == wbpt_pkg::SLOT_W'(wbpt_pkg::RING_SLOTS - 1)) ?
                            '0 : wslot_r + wbpt_pkg::SLOT_W'(1);
          if (fill_r < wbpt_pkg::FILL_W'(wbpt_pkg::RING_SLOTS)) begin
            fill_nxt = fill_r + wbpt_pkg::FILL_W'(1);
          end
          commit_wall_nxt = wall_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = held_r;
          out_stat_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      window_r      <= '0;
      prev_busy_r   <= '0;
      prev_wall_r   <= '0;
      commit_wall_r <= '0;
      seen_first_r  <= 1'b0;
      fill_r        <= '0;
      wslot_r       <= '0;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      prev_busy_r   <= prev_busy_nxt;
      prev_wall_r   <= prev_wall_nxt;
      commit_wall_r <= commit_wall_nxt;
      seen_first_r  <= seen_first_nxt;
      fill_r        <= fill_nxt;
      wslot_r       <= wslot_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    busy_r     <= busy_nxt;
    wall_r     <= wall_nxt;
    db_r       <= db_nxt;
    dw_r       <= dw_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    status_r   <= status_nxt;
    out_pct_r  <= out_pct_nxt;
    out_stat_r <= out_stat_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= wbpt_pkg::FILL_W'(wbpt_pkg::RING_SLOTS))
    else $error("ring fill beyond depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_first_r && fill_r < wbpt_pkg::FILL_W'(wbpt_pkg::RING_SLOTS)) |->
    (wslot_r == fill_r[wbpt_pkg::SLOT_W-1:0]))
    else $error("write slot out of step with ring fill");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= PCT_FULL))
    else $error("percent above full scale");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_bus.ready)
    else $error("sample taken while sequencer busy");
`endif

endmodule

FILE: tb/windowed_busy_percent_tracker_top_tb.sv
module windowed_busy_percent_tracker_top_tb;
  import wbpt_pkg::*;

  localparam int               CYCLE_LIMIT = 400000;
  localparam int               MAX_REPORTS = 10;
  localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
  localparam logic [63:0]      CNT_TOP     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [STAT_W-1:0] {
    ST_BASELINE   = 2'd0,
    ST_RECOMPUTED = 2'd1,
    ST_HELD       = 2'd2,
    ST_REBASED    = 2'd3
  } sample_status_t;

  typedef struct {
    logic [CNT_W-1:0] busy;
    logic [CNT_W-1:0] wall;
  } counter_sample_t;

  typedef struct {
    logic [PCT_W-1:0] pct;
    sample_status_t   stat;
  } busy_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  logic             drv_valid = 1'b0;
  logic [CNT_W-1:0] drv_busy = '0;
  logic [CNT_W-1:0] drv_wall = '0;
  logic             drv_ready = 1'b0;

  wbpt_in_if  in_bus ();
  wbpt_out_if out_bus ();

  assign in_bus.valid      = drv_valid;
  assign in_bus.busy_count = drv_busy;
  assign in_bus.wall_count = drv_wall;
  assign out_bus.ready     = drv_ready;

  windowed_busy_percent_tracker_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  // stimulus and expectation stores
  counter_sample_t sample_q[$];
  busy_result_t    percent_q[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  in_beats = 0;
  int  in_beats_seen = 0;
  bit  no_idle = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  // predictor state
  logic [CNT_W-1:0]  span_reg = '0;
  bit                seen_first = 1'b0;
  logic [CNT_W-1:0]  prior_busy = '0;
  logic [CNT_W-1:0]  prior_wall = '0;
  logic [CNT_W-1:0]  commit_at = '0;
  logic [CNT_W-1:0]  ckpt_busy [RING_SLOTS];
  logic [CNT_W-1:0]  ckpt_wall [RING_SLOTS];
  logic [FILL_W-1:0] ckpt_fill = '0;
  logic [SLOT_W-1:0] ckpt_slot = '0;
  logic [PCT_W-1:0]  held_pct = '0;

  // running counters for the random part
  logic [CNT_W-1:0] run_busy = '0;
  logic [CNT_W-1:0] run_wall = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // windowed percentage against the oldest checkpoint
  function automatic busy_result_t track_sample(input logic [CNT_W-1:0] busy,
                                                input logic [CNT_W-1:0] wall);
    busy_result_t      res;
    logic [SLOT_W-1:0] oldest;
    logic [CNT_W-1:0]  db, dw, win, spacing;
    logic [127:0]      scaled;
    if (!seen_first) begin
      seen_first   = 1'b1;
      prior_busy   = busy;
      prior_wall   = wall;
      commit_at    = wall;
      ckpt_busy[0] = busy;
      ckpt_wall[0] = wall;
      ckpt_fill    = FILL_W'(1);
      ckpt_slot    = (RING_SLOTS > 1) ? SLOT_W'(1) : '0;
      res.pct      = held_pct;
      res.stat     = ST_BASELINE;
      return res;
    end
    if (busy < prior_busy || wall < prior_wall) begin
      prior_busy = busy;
      prior_wall = wall;
      res.pct    = held_pct;
      res.stat   = ST_REBASED;
      return res;
    end
    prior_busy = busy;
    prior_wall = wall;

    oldest = (ckpt_fill < FILL_W'(RING_SLOTS)) ? '0 : ckpt_slot;
    if (wall > ckpt_wall[oldest]) begin
      db = busy - ckpt_busy[oldest];
      dw = wall - ckpt_wall[oldest];
      if (db >= dw) begin
        held_pct = PCT_FULL;
      end else begin
        scaled   = {64'd0, db} * 128'd100;
        scaled   = scaled / {64'd0, dw};
        held_pct = scaled[PCT_W-1:0];
      end
      res.stat = ST_RECOMPUTED;
    end else begin
      res.stat = ST_HELD;
    end

    // checkpoint commit, spacing is window / slots but at least one unit
    win     = (span_reg == '0) ? 64'd1 : span_reg;
    spacing = win / 64'(RING_SLOTS);
    if (spacing == '0) spacing = 64'd1;
    if (wall - commit_at >= spacing) begin
      ckpt_busy[ckpt_slot] = busy;
      ckpt_wall[ckpt_slot] = wall;
      ckpt_slot = (ckpt_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : ckpt_slot + SLOT_W'(1);
      if (ckpt_fill < FILL_W'(RING_SLOTS)) ckpt_fill = ckpt_fill + FILL_W'(1);
      commit_at = wall;
    end
    res.pct = held_pct;
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin
    counter_sample_t s;
    logic next_valid;
    next_valid = drv_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (drv_valid && in_beats != in_beats_seen) begin
        next_valid = 1'b0;
      end
      in_beats_seen = in_beats;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() > 0) begin
          s = sample_q.pop_front();
          drv_busy <= s.busy;
          drv_wall <= s.wall;
          next_valid = 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end
      end
    end
    drv_valid <= next_valid;
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      drv_ready <= 1'b0;
    end else begin
      drv_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    busy_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        percent_q.push_back(track_sample(in_bus.busy_count, in_bus.wall_count));
        in_beats++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (percent_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: pct %0d status %0d",
                     out_bus.busy_percent, out_bus.sample_status);
        end else begin
          want = percent_q.pop_front();
          if (out_bus.busy_percent !== want.pct ||
              out_bus.sample_status !== want.stat) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected pct %0d status %0d, got pct %0d status %0d",
                       want.pct, want.stat, out_bus.busy_percent,
                       out_bus.sample_status);
          end
        end
      end
    end
  end

  task automatic add_sample(input logic [CNT_W-1:0] busy, input logic [CNT_W-1:0] wall);
    counter_sample_t s;
    s.busy = busy;
    s.wall = wall;
    sample_q.push_back(s);
  endtask

  // block until every queued beat went in and every result came back
  task automatic wait_drained();
    while (!(sample_q.size() == 0 && percent_q.size() == 0 && !drv_valid))
      @(posedge clk);
  endtask

  task automatic write_span(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    span_reg   = value;
  endtask

  // mostly monotonic counters, some rebases, stalls of wall time and noise
  task automatic add_random(input int n);
    int               r;
    logic [CNT_W-1:0] lim, dw, db;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      lim = (span_reg >> 4) * 64'd2 + 64'd4;
      dw  = rand64() % lim;
      if (r < 5) begin
        run_busy = rand64();
        run_wall = rand64();
      end else if (r < 12) begin
        if ($urandom_range(0, 2) != 0) run_busy = run_busy >> $urandom_range(1, 8);
        if ($urandom_range(0, 2) != 0) run_wall = run_wall >> $urandom_range(1, 8);
      end else if (r < 17) begin
        run_busy += 64'($urandom_range(0, 3));
      end else if (r < 20) begin
        run_wall = CNT_TOP - 64'($urandom_range(0, 1000));
        run_busy = run_wall - 64'($urandom_range(0, 1000));
      end else begin
        if ($urandom_range(0, 9) == 0) db = dw + 64'($urandom_range(0, 5));
        else db = rand64() % (dw + 64'd1);
        run_wall += dw;
        run_busy += db;
      end
      add_sample(run_busy, run_wall);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] spans [8];
    spans = '{CNT_TOP, 64'd0, 64'd16, 64'd15, 64'd17, 64'd1000,
              64'(rand64() >> 40), 64'd1 << 40};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    write_span('0);

    // directed: baseline, held, plain and saturated share, rebases,
    // busy below the checkpoint, full-width counters, wall below commit point
    add_sample(64'd1000, 64'd100);
    add_sample(64'd1000, 64'd100);
    add_sample(64'd1050, 64'd200);
    add_sample(64'd1300, 64'd300);
    add_sample(64'd5, 64'd400);
    add_sample(64'd6, 64'd500);
    add_sample(64'd7, 64'd450);
    add_sample(CNT_TOP - 64'd1, CNT_TOP);
    add_sample(CNT_TOP, CNT_TOP);
    add_sample(64'd0, 64'd0);
    add_sample(64'd0, 64'd1);
    // run the ring past its wrap point
    for (int i = 1; i <= 14; i++) add_sample(64'(i * 7), 64'(i * 10 + 1));
    wait_drained();

    foreach (spans[p]) begin
      write_span(spans[p]);
      no_idle = (p == 2 || p == 5);
      add_random(72);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (25) @(posedge clk);
    if (fail_count == 0 && percent_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
